/* src/qse_pkg.sv */
// qse_pkg: shared types, widths and constants of the quadrature speed estimator
// no dependencies; used by the interfaces, the arithmetic unit and the top level
package qse_pkg;

  localparam int WINDOW_MAX_DEF = 16;

  // payload widths
  localparam int KIND_W  = 2;
  localparam int DATA_W  = 32;
  localparam int CFG_DATA_W  = 40;
  localparam int CFG_INDEX_W = 3;

  // shared arithmetic unit widths
  localparam int ACC_W   = 72;
  localparam int OPB_W   = 32;
  localparam int MCAND_W = 49;
  localparam int STEP_W  = $clog2(ACC_W + 1);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PIN      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INDEX    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RPM_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VEL_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DST_GAIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT  = 3'd6;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  // 4x decode: index is {previous a, previous b, a, b}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0,
    2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef enum logic {
    ARITH_MUL,
    ARITH_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW_MUL,
    ST_RAW_DIV,
    ST_HIST,
    ST_SLOT_DIV,
    ST_AVG,
    ST_AVG_DIV,
    ST_FILTER,
    ST_IIR_MUL,
    ST_VEL,
    ST_VEL_MUL,
    ST_DIST_MUL,
    ST_OUT
  } state_t;

endpackage

/* src/qse_in_if.sv */
// qse_in_if: input channel carrying encoder events and sample requests
// depends on qse_pkg
interface qse_in_if;
  import qse_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              pin_a;
  logic              pin_b;
  logic [DATA_W-1:0] elapsed_us;

  modport source (output valid, kind, pin_a, pin_b, elapsed_us, input ready);
  modport sink (input valid, kind, pin_a, pin_b, elapsed_us, output ready);
endinterface

/* src/qse_out_if.sv */
// qse_out_if: result channel carrying speed, velocity, distance and revolutions
// depends on qse_pkg
interface qse_out_if;
  import qse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] speed_centi;
  logic signed [DATA_W-1:0] velocity_mm_s;
  logic signed [DATA_W-1:0] distance_mm;
  logic                     distance_negative;
  logic signed [DATA_W-1:0] revolutions;

  modport source (output valid, speed_centi, velocity_mm_s, distance_mm, distance_negative,
                  revolutions, input ready);
  modport sink (input valid, speed_centi, velocity_mm_s, distance_mm, distance_negative,
                revolutions, output ready);
endinterface

/* src/qse_arith.sv */
// qse_arith: shared shift-add multiplier and shift-subtract divider, one bit per cycle
// depends on qse_pkg
module qse_arith (
  input  logic                      clk,
  input  logic                      rst,
  input  qse_pkg::arith_cmd_t       cmd,
  input  logic [qse_pkg::ACC_W-1:0] opa,
  input  logic [qse_pkg::OPB_W-1:0] opb,
  output logic                      done,
  output logic [qse_pkg::ACC_W-1:0] result,
  output logic [qse_pkg::OPB_W-1:0] remainder
);
  import qse_pkg::*;

  logic [ACC_W-1:0]   acc;
  logic [MCAND_W-1:0] mcand;
  logic [OPB_W-1:0]   breg;
  logic [OPB_W-1:0]   rem;
  logic [STEP_W-1:0]  steps;
  arith_op_t          op;
  logic               busy;
  logic [OPB_W:0]     rem_sh;
  logic               take;

  always_comb begin
    rem_sh = {rem, acc[ACC_W-1]};
    take   = rem_sh >= {1'b0, breg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        breg <= opb;
        rem  <= '0;
        unique case (cmd.op)
          ARITH_MUL: begin
            acc   <= '0;
            mcand <= opa[MCAND_W-1:0];
            steps <= STEP_W'(OPB_W);
          end
          ARITH_DIV: begin
            acc   <= opa;
            steps <= STEP_W'(ACC_W);
          end
        endcase
      end else if (busy) begin
        unique case (op)
          ARITH_MUL: begin
            // msb first: shift the partial product, add when the multiplier bit is set
            acc  <= (acc << 1) + (breg[OPB_W-1] ? ACC_W'(mcand) : '0);
            breg <= breg << 1;
          end
          ARITH_DIV: begin
            acc <= {acc[ACC_W-2:0], take};
            rem <= take ? OPB_W'(rem_sh - {1'b0, breg}) : rem_sh[OPB_W-1:0];
          end
        endcase
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result    = acc;
  assign remainder = rem;

endmodule

/* src/quadrature_speed_estimator_top.sv */
// quadrature_speed_estimator_top: 4x quadrature decode, index counting and filtered speed
// depends on qse_pkg, qse_in_if, qse_out_if and qse_arith
//
//   port      dir  kind           carries
//   encoder   in   valid/ready    kind, pin_a, pin_b, elapsed_us
//   estimate  out  valid/ready    speed_centi, velocity_mm_s, distance_mm,
//                                 distance_negative, revolutions
//   cfg_*     in   write enable   cfg_index, cfg_data
//
// pin change and index transactions give no result.
// a sample holds the input while it uses the shared unit for up to four multiplies
// and three divides.
// encoder.ready is high only in the idle state; a finished result waits in the
// output register, and a new sample stalls at its end while that register is full.
// rst is synchronous; it clears counters and filter state and resets the configuration registers.
module quadrature_speed_estimator_top #(
  parameter int WINDOW_MAX = qse_pkg::WINDOW_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qse_pkg::CFG_DATA_W-1:0]  cfg_data,
  qse_in_if.sink                          encoder,
  qse_out_if.source                       estimate
);
  import qse_pkg::*;

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = 40;
  localparam int SM_W   = 48;
  localparam logic [ACC_W-1:0] MAG_LIMIT = ACC_W'(64'h8000_0000);

  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [ACC_W-1:0] mag);
    logic signed [31:0] r;
    if (neg) r = (mag >= MAG_LIMIT) ? 32'sh8000_0000 : -$signed(mag[31:0]);
    else     r = (mag >= MAG_LIMIT) ? 32'sh7fff_ffff : $signed(mag[31:0]);
    return r;
  endfunction

  // configuration
  logic              invert;
  logic [39:0]       rpm_gain;
  logic [31:0]       vel_gain;
  logic [31:0]       dst_gain;
  logic [4:0]        avg_window;
  logic [16:0]       alpha;
  logic [31:0]       timeout_us;

  // counters and filter state
  logic [1:0]               prev_ab;
  logic [31:0]              count_total;
  logic [31:0]              rev_total;
  logic [31:0]              count_last;
  logic [31:0]              idle_time;
  logic signed [31:0]       hist_mem [WINDOW_MAX];
  logic signed [31:0]       hist_q;
  logic [SLOT_W-1:0]        slot;
  logic [FILL_W-1:0]        fill;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SM_W-1:0]   smoothed;
  logic                     primed;

  // per-sample working registers
  state_t             state, state_next;
  logic [31:0]        elapsed_q;
  logic               neg_q;
  logic               dzero_q;
  logic               idl_q;
  logic               diff_neg_q;
  logic signed [31:0] raw;
  logic signed [31:0] avg;
  logic signed [31:0] rpm;
  logic signed [31:0] vel;
  logic signed [31:0] dist_mm;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_rpm, out_vel, out_dist, out_rev;
  logic                     out_neg;

  // shared unit
  arith_cmd_t        cmd;
  logic [ACC_W-1:0]  opa;
  logic [OPB_W-1:0]  opb;
  logic              ar_done;
  logic [ACC_W-1:0]  ar_result;
  logic [OPB_W-1:0]  ar_rem;

  // combinational helpers
  logic [31:0]              delta, dmag;
  logic [FILL_W-1:0]        win;
  logic [16:0]              alpha_c;
  logic                     tmo, idl, hist_upd;
  logic [SUM_W-1:0]         sum_mag;
  logic signed [SM_W:0]     diff;
  logic [SM_W:0]            diff_mag;
  logic signed [SM_W+1:0]   sm_wide;
  logic signed [SM_W-1:0]   sm_next;
  logic [SM_W-1:0]          sm_mag;
  logic signed [31:0]       sm_rpm;
  logic [31:0]              rpm_mag, cnt_mag;
  logic [32:0]              idle_add;
  logic signed [1:0]        step;
  logic                     fwd;
  logic                     in_xact, out_xact;

  always_comb begin
    delta    = count_total - count_last;
    dmag     = delta[31] ? (~delta + 32'd1) : delta;
    if (avg_window == 5'd0) win = FILL_W'(1);
    else if (32'(avg_window) > WINDOW_MAX) win = FILL_W'(WINDOW_MAX);
    else win = FILL_W'(avg_window);
    alpha_c  = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    tmo      = idle_time >= timeout_us;
    idl      = idle_time != 32'd0;
    hist_upd = !tmo && !idl && (elapsed_q != 32'd0);
    sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    diff     = $signed({avg[31], avg, 16'h0000}) - $signed({smoothed[SM_W-1], smoothed});
    diff_mag = diff[SM_W] ? (SM_W+1)'(-diff) : (SM_W+1)'(diff);
    // step toward the new average: the truncated product moves by at most |diff|
    sm_wide  = diff_neg_q ? ((SM_W+2)'(smoothed) - $signed({1'b0, ar_result[16 +: SM_W+1]}))
                          : ((SM_W+2)'(smoothed) + $signed({1'b0, ar_result[16 +: SM_W+1]}));
    sm_next  = sm_wide[SM_W-1:0];
    sm_mag   = smoothed[SM_W-1] ? SM_W'(-smoothed) : SM_W'(smoothed);
    sm_rpm   = sat_mag(smoothed[SM_W-1], ACC_W'(sm_mag) >> 16);
    rpm_mag  = rpm[31] ? 32'(-rpm) : 32'(rpm);
    cnt_mag  = count_total[31] ? (~count_total + 32'd1) : count_total;
    idle_add = {1'b0, idle_time} + {1'b0, elapsed_q};
    step     = STEP_TABLE[{prev_ab, encoder.pin_a, encoder.pin_b}];
    fwd      = !encoder.pin_b ^ invert;
    in_xact  = encoder.valid && encoder.ready;
    out_xact = estimate.valid && estimate.ready;
  end

  qse_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opa       (opa),
    .opb       (opb),
    .done      (ar_done),
    .result    (ar_result),
    .remainder (ar_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd.start     = 1'b0;
    cmd.op        = ARITH_MUL;
    opa           = '0;
    opb           = '0;
    encoder.ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (encoder.valid && encoder.kind == KIND_SAMPLE) begin
          if (encoder.elapsed_us != 32'd0) begin
            cmd.start  = 1'b1;
            opa        = ACC_W'(rpm_gain);
            opb        = dmag;
            state_next = ST_RAW_MUL;
          end else begin
            state_next = ST_HIST;
          end
        end
      end
      ST_RAW_MUL: begin
        if (ar_done) begin
          cmd.start  = 1'b1;
          cmd.op     = ARITH_DIV;
          opa        = ar_result;
          opb        = elapsed_q;
          state_next = ST_RAW_DIV;
        end
      end
      ST_RAW_DIV: if (ar_done) state_next = ST_HIST;
      ST_HIST: begin
        if (tmo) begin
          state_next = ST_VEL;
        end else if (hist_upd) begin
          cmd.start  = 1'b1;
          cmd.op     = ARITH_DIV;
          opa        = ACC_W'(slot) + ACC_W'(1);
          opb        = OPB_W'(win);
          state_next = ST_SLOT_DIV;
        end else begin
          state_next = ST_AVG;
        end
      end
      ST_SLOT_DIV: if (ar_done) state_next = ST_AVG;
      ST_AVG: begin
        if (idl_q) begin
          state_next = ST_VEL;
        end else if (fill == '0) begin
          state_next = ST_FILTER;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = ARITH_DIV;
          opa        = ACC_W'(sum_mag);
          opb        = OPB_W'(fill);
          state_next = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: if (ar_done) state_next = ST_FILTER;
      ST_FILTER: begin
        if (!primed) begin
          state_next = ST_VEL;
        end else begin
          cmd.start  = 1'b1;
          opa        = ACC_W'(diff_mag);
          opb        = OPB_W'(alpha_c);
          state_next = ST_IIR_MUL;
        end
      end
      ST_IIR_MUL: if (ar_done) state_next = ST_VEL;
      ST_VEL: begin
        cmd.start  = 1'b1;
        opa        = ACC_W'(rpm_mag);
        opb        = vel_gain;
        state_next = ST_VEL_MUL;
      end
      ST_VEL_MUL: begin
        if (ar_done) begin
          cmd.start  = 1'b1;
          opa        = ACC_W'(cnt_mag);
          opb        = dst_gain;
          state_next = ST_DIST_MUL;
        end
      end
      ST_DIST_MUL: if (ar_done) state_next = ST_OUT;
      ST_OUT: if (!out_valid || estimate.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      invert     <= 1'b0;
      rpm_gain   <= '0;
      vel_gain   <= '0;
      dst_gain   <= '0;
      avg_window <= 5'd1;
      alpha      <= ALPHA_ONE;
      timeout_us <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INVERT:   invert     <= cfg_data[0];
        CFG_RPM_GAIN: rpm_gain   <= cfg_data[39:0];
        CFG_VEL_GAIN: vel_gain   <= cfg_data[31:0];
        CFG_DST_GAIN: dst_gain   <= cfg_data[31:0];
        CFG_WINDOW:   avg_window <= cfg_data[4:0];
        CFG_ALPHA:    alpha      <= cfg_data[16:0];
        CFG_TIMEOUT:  timeout_us <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // history store
  always_ff @(posedge clk) begin
    if (state == ST_HIST && hist_upd) hist_mem[slot] <= raw;
    hist_q <= hist_mem[slot];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab     <= '0;
      count_total <= '0;
      rev_total   <= '0;
      count_last  <= '0;
      idle_time   <= '0;
      slot        <= '0;
      fill        <= '0;
      sum         <= '0;
      smoothed    <= '0;
      primed      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the output state reloads the register itself
      if (out_xact && state != ST_OUT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_xact) begin
            if (encoder.kind == KIND_PIN) begin
              prev_ab <= {encoder.pin_a, encoder.pin_b};
              if (step != 2'sd0) begin
                if ((step > 2'sd0) ^ invert) count_total <= count_total + 32'd1;
                else                          count_total <= count_total - 32'd1;
              end
            end else if (encoder.kind == KIND_INDEX) begin
              if (fwd) rev_total <= rev_total + 32'd1;
              else     rev_total <= rev_total - 32'd1;
            end else if (encoder.kind == KIND_SAMPLE) begin
              elapsed_q <= encoder.elapsed_us;
              neg_q     <= delta[31];
              dzero_q   <= (delta == 32'd0);
              raw       <= '0;
            end
          end
        end
        ST_RAW_DIV: begin
          if (ar_done) begin
            raw        <= sat_mag(neg_q, ar_result);
            count_last <= count_total;
            if (dzero_q) idle_time <= idle_add[32] ? 32'hffff_ffff : idle_add[31:0];
            else         idle_time <= '0;
          end
        end
        ST_HIST: begin
          idl_q <= idl;
          if (tmo) begin
            slot     <= '0;
            fill     <= '0;
            sum      <= '0;
            smoothed <= '0;
            primed   <= 1'b0;
            rpm      <= '0;
          end else if (hist_upd) begin
            if (fill < win) begin
              fill <= fill + 1'b1;
              sum  <= sum + SUM_W'(raw);
            end else begin
              sum  <= sum - SUM_W'(hist_q) + SUM_W'(raw);
            end
          end
        end
        ST_SLOT_DIV: if (ar_done) slot <= ar_rem[SLOT_W-1:0];
        ST_AVG: begin
          if (idl_q) rpm <= primed ? sm_rpm : '0;
          else if (fill == '0) avg <= '0;
        end
        ST_AVG_DIV: if (ar_done) avg <= sat_mag(sum[SUM_W-1], ar_result);
        ST_FILTER: begin
          diff_neg_q <= diff[SM_W];
          if (!primed) begin
            smoothed <= $signed({avg, 16'h0000});
            primed   <= 1'b1;
            rpm      <= avg;
          end
        end
        ST_IIR_MUL: begin
          if (ar_done) begin
            smoothed <= sm_next;
            rpm      <= sat_mag(sm_next[SM_W-1],
                                ACC_W'(sm_next[SM_W-1] ? SM_W'(-sm_next) : SM_W'(sm_next)) >> 16);
          end
        end
        ST_VEL_MUL: if (ar_done) vel <= sat_mag(rpm[31], ar_result >> 16);
        ST_DIST_MUL: if (ar_done) dist_mm <= sat_mag(count_total[31], ar_result >> 16);
        ST_OUT: begin
          if (!out_valid || estimate.ready) begin
            out_valid <= 1'b1;
            out_rpm   <= rpm;
            out_vel   <= vel;
            out_dist  <= dist_mm;
            out_neg   <= count_total[31];
            out_rev   <= rev_total;
          end
        end
        default: ;
      endcase
    end
  end

  assign estimate.valid             = out_valid;
  assign estimate.speed_centi       = out_rpm;
  assign estimate.velocity_mm_s     = out_vel;
  assign estimate.distance_mm       = out_dist;
  assign estimate.distance_negative = out_neg;
  assign estimate.revolutions       = out_rev;

endmodule
